### sv/vccpa_pkg.sv
`default_nettype none

package vccpa_pkg;

   // Field widths of the request and response beats
   localparam int COORD_W    = 10;
   localparam int CH_W       = 2;
   localparam int SIZE_W     = 11;
   localparam int INDEX_W    = 32;
   localparam int FILL_W     = 16;
   localparam int NUM_FILL   = 3;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   // Horner partial sums: (c*size_z + z) and ((c*size_z + z)*size_y + y)
   localparam int T1_W = SIZE_W + CH_W;
   localparam int T2_W = T1_W + SIZE_W;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IN_SIZE_X   = 3'd0,
      REG_IN_SIZE_Y   = 3'd1,
      REG_IN_SIZE_Z   = 3'd2,
      REG_OUT_SIZE_X  = 3'd3,
      REG_OUT_SIZE_Y  = 3'd4,
      REG_OUT_SIZE_Z  = 3'd5,
      REG_FILL_VALUES = 3'd6
   } csr_reg_type;

   // Per-axis placement of the source inside the output volume.
   // grow: output at least as large as source, offset is the pad start and
   // limit the first output coordinate past the source; otherwise offset is
   // the crop start.
   typedef struct packed {
      logic              grow;
      logic [SIZE_W-1:0] offset;
      logic [SIZE_W:0]   limit;
      logic [SIZE_W-1:0] in_size;
      logic [SIZE_W-1:0] out_size;
   } axis_geom_type;

endpackage

`default_nettype wire

### sv/vccpa_csr.sv
`default_nettype none

module vccpa_csr
   import vccpa_pkg::*;
#(
   parameter int MAX_DIM    = 1024,
   parameter int PIXEL_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]      csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_write_data,
   output axis_geom_type                  geom_x,
   output axis_geom_type                  geom_y,
   output axis_geom_type                  geom_z,
   output logic [NUM_FILL-1:0][PIXEL_BITS-1:0] fill_values
);

   localparam logic [SIZE_W+1:0] DIM_LIMIT = (SIZE_W+2)'(MAX_DIM);

   logic [SIZE_W-1:0] in_x_ff,  in_y_ff,  in_z_ff;
   logic [SIZE_W-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic [NUM_FILL-1:0][PIXEL_BITS-1:0] fill_ff;
   axis_geom_type geom_x_ff, geom_y_ff, geom_z_ff;
   logic [SIZE_W-1:0] size_in;

   // Zero counts as one, anything above the limit as the limit
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if ({2'b00, v} > DIM_LIMIT) begin
         r = SIZE_W'(MAX_DIM);
      end
      return r;
   endfunction

   // Centering offsets of one axis
   function automatic axis_geom_type geom_of(input logic [SIZE_W-1:0] in_size,
                                             input logic [SIZE_W-1:0] out_size);
      axis_geom_type g;
      logic [SIZE_W:0] diff;
      g.in_size  = in_size;
      g.out_size = out_size;
      g.grow     = (out_size >= in_size);
      if (g.grow) begin
         diff = {1'b0, out_size} - {1'b0, in_size} + (SIZE_W+1)'(1);
      end else begin
         diff = {1'b0, in_size} - {1'b0, out_size} - (SIZE_W+1)'(1);
      end
      g.offset = diff[SIZE_W:1];
      g.limit  = {1'b0, g.offset} + {1'b0, in_size};
      return g;
   endfunction

   assign size_in = clamp_size(csr_write_data[SIZE_W-1:0]);

   // Take register writes, sizes stored already clamped
   always_ff @(posedge clock) begin
      if (reset) begin
         in_x_ff  <= SIZE_W'(1);
         in_y_ff  <= SIZE_W'(1);
         in_z_ff  <= SIZE_W'(1);
         out_x_ff <= SIZE_W'(1);
         out_y_ff <= SIZE_W'(1);
         out_z_ff <= SIZE_W'(1);
         fill_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_IN_SIZE_X:   in_x_ff  <= size_in;
            REG_IN_SIZE_Y:   in_y_ff  <= size_in;
            REG_IN_SIZE_Z:   in_z_ff  <= size_in;
            REG_OUT_SIZE_X:  out_x_ff <= size_in;
            REG_OUT_SIZE_Y:  out_y_ff <= size_in;
            REG_OUT_SIZE_Z:  out_z_ff <= size_in;
            REG_FILL_VALUES: begin
               for (int k = 0; k < NUM_FILL; k++) begin
                  fill_ff[k] <= csr_write_data[k*FILL_W +: PIXEL_BITS];
               end
            end
            default: ;
         endcase
      end
   end

   // Derive axis geometry from the size registers, in a register of its own
   always_ff @(posedge clock) begin
      if (reset) begin
         geom_x_ff <= geom_of(SIZE_W'(1), SIZE_W'(1));
         geom_y_ff <= geom_of(SIZE_W'(1), SIZE_W'(1));
         geom_z_ff <= geom_of(SIZE_W'(1), SIZE_W'(1));
      end else begin
         geom_x_ff <= geom_of(in_x_ff, out_x_ff);
         geom_y_ff <= geom_of(in_y_ff, out_y_ff);
         geom_z_ff <= geom_of(in_z_ff, out_z_ff);
      end
   end

   assign geom_x      = geom_x_ff;
   assign geom_y      = geom_y_ff;
   assign geom_z      = geom_z_ff;
   assign fill_values = fill_ff;

endmodule

`default_nettype wire

### sv/vccpa_axis_map.sv
`default_nettype none

module vccpa_axis_map
   import vccpa_pkg::*;
(
   input  wire logic [COORD_W-1:0] coord,
   input  axis_geom_type           geom,
   output logic                    hit,
   output logic [SIZE_W-1:0]       src
);

   logic [SIZE_W-1:0] coord_ext;

   assign coord_ext = SIZE_W'(coord);

   // Pad: inside only between pad start and its end; crop: always inside
   always_comb begin
      if (geom.grow) begin
         hit = (coord_ext >= geom.offset) && ({1'b0, coord_ext} < geom.limit);
         src = coord_ext - geom.offset;
      end else begin
         hit = 1'b1;
         src = coord_ext + geom.offset;
      end
   end

endmodule

`default_nettype wire

### sv/vccpa_mac.sv
`default_nettype none

module vccpa_mac #(
   parameter int A_W   = 13,
   parameter int B_W   = 11,
   parameter int ADD_W = 10,
   parameter int OUT_W = 24
) (
   input  wire logic             clock,
   input  wire logic [A_W-1:0]   a,
   input  wire logic [B_W-1:0]   b,
   input  wire logic [ADD_W-1:0] addend,
   output logic      [OUT_W-1:0] q
);

   localparam int PROD_W = A_W + B_W;

   logic [PROD_W-1:0] prod;
   logic [PROD_W:0]   sum;
   logic [OUT_W-1:0]  q_ff;

   // One Horner step: a * b + addend, registered
   assign prod = a * b;
   assign sum  = {1'b0, prod} + (PROD_W+1)'(addend);

   always_ff @(posedge clock) begin
      q_ff <= OUT_W'(sum);
   end

   assign q = q_ff;

endmodule

`default_nettype wire

### sv/volume_center_crop_pad_address.sv
`default_nettype none

// Center crop-or-pad address generator. One voxel coordinate is taken on
// every clock at which start is high; busy never rises. Its response appears
// on the rsp_ ports at the end of the pipeline for one cycle, marked by
// rsp_strobe, and must be taken then. Each pipeline stage does one of the
// three multiply-add steps that build each linear index. A configuration
// write passes the size register, then the geometry register, before it
// reaches the address logic; write only while no beat is in flight. A coordinate
// or channel out of range gives rsp_coord_error with all other response fields zero.
module volume_center_crop_pad_address
   import vccpa_pkg::*;
#(
   parameter int MAX_DIM      = 1024,
   parameter int PIXEL_BITS   = 16,
   parameter int MAX_CHANNELS = 3
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [COORD_W-1:0]    req_out_x,
   input  wire logic [COORD_W-1:0]    req_out_y,
   input  wire logic [COORD_W-1:0]    req_out_z,
   input  wire logic [CH_W-1:0]       req_channel,
   output logic                       rsp_strobe,
   output logic                       rsp_from_source,
   output logic [INDEX_W-1:0]         rsp_source_index,
   output logic [INDEX_W-1:0]         rsp_dest_index,
   output logic [FILL_W-1:0]          rsp_fill_value,
   output logic                       rsp_coord_error,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam logic [CH_W-1:0] CH_LIMIT = CH_W'(MAX_CHANNELS);

   axis_geom_type geom_x, geom_y, geom_z;
   logic [NUM_FILL-1:0][PIXEL_BITS-1:0] fill_values;

   logic                  accept;
   logic                  in_x, in_y, in_z;
   logic [SIZE_W-1:0]     src_x, src_y, src_z;
   logic                  err_in;
   logic [PIXEL_BITS-1:0] fill_in;

   // Stage 1
   logic                  valid1_ff, err1_ff, inside1_ff;
   logic [COORD_W-1:0]    x1_ff, y1_ff;
   logic [SIZE_W-1:0]     sx1_ff, sy1_ff;
   logic [PIXEL_BITS-1:0] fill1_ff;
   logic [T1_W-1:0]       dst1, src1;
   // Stage 2
   logic                  valid2_ff, err2_ff, inside2_ff;
   logic [COORD_W-1:0]    x2_ff;
   logic [SIZE_W-1:0]     sx2_ff;
   logic [PIXEL_BITS-1:0] fill2_ff;
   logic [T2_W-1:0]       dst2, src2;
   // Stage 3
   logic                  valid3_ff, err3_ff, inside3_ff;
   logic [PIXEL_BITS-1:0] fill3_ff;
   logic [INDEX_W-1:0]    dst3, src3;

   vccpa_csr #(
      .MAX_DIM    (MAX_DIM),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .geom_x           (geom_x),
      .geom_y           (geom_y),
      .geom_z           (geom_z),
      .fill_values      (fill_values)
   );

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Map each axis onto the source volume
   vccpa_axis_map u_map_x (.coord(req_out_x), .geom(geom_x), .hit(in_x), .src(src_x));
   vccpa_axis_map u_map_y (.coord(req_out_y), .geom(geom_y), .hit(in_y), .src(src_y));
   vccpa_axis_map u_map_z (.coord(req_out_z), .geom(geom_z), .hit(in_z), .src(src_z));

   // Range check and fill lookup
   assign err_in = (SIZE_W'(req_out_x) >= geom_x.out_size)
                || (SIZE_W'(req_out_y) >= geom_y.out_size)
                || (SIZE_W'(req_out_z) >= geom_z.out_size)
                || (req_channel >= CH_LIMIT);

   always_comb begin
      fill_in = '0;
      if (req_channel < CH_W'(NUM_FILL)) begin
         fill_in = fill_values[req_channel];
      end
   end

   // Stage 1: channel * size_z + z on both volumes
   vccpa_mac #(.A_W(CH_W), .B_W(SIZE_W), .ADD_W(COORD_W), .OUT_W(T1_W)) u_dst1 (
      .clock(clock), .a(req_channel), .b(geom_z.out_size), .addend(req_out_z), .q(dst1)
   );
   vccpa_mac #(.A_W(CH_W), .B_W(SIZE_W), .ADD_W(SIZE_W), .OUT_W(T1_W)) u_src1 (
      .clock(clock), .a(req_channel), .b(geom_z.in_size), .addend(src_z), .q(src1)
   );

   // Stage 2: fold in the row
   vccpa_mac #(.A_W(T1_W), .B_W(SIZE_W), .ADD_W(COORD_W), .OUT_W(T2_W)) u_dst2 (
      .clock(clock), .a(dst1), .b(geom_y.out_size), .addend(y1_ff), .q(dst2)
   );
   vccpa_mac #(.A_W(T1_W), .B_W(SIZE_W), .ADD_W(SIZE_W), .OUT_W(T2_W)) u_src2 (
      .clock(clock), .a(src1), .b(geom_y.in_size), .addend(sy1_ff), .q(src2)
   );

   // Stage 3: fold in the column, wrap to 32 bits
   vccpa_mac #(.A_W(T2_W), .B_W(SIZE_W), .ADD_W(COORD_W), .OUT_W(INDEX_W)) u_dst3 (
      .clock(clock), .a(dst2), .b(geom_x.out_size), .addend(x2_ff), .q(dst3)
   );
   vccpa_mac #(.A_W(T2_W), .B_W(SIZE_W), .ADD_W(SIZE_W), .OUT_W(INDEX_W)) u_src3 (
      .clock(clock), .a(src2), .b(geom_x.in_size), .addend(sx2_ff), .q(src3)
   );

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid1_ff <= accept;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   // Carry side data alongside the indexes
   always_ff @(posedge clock) begin
      err1_ff    <= err_in;
      inside1_ff <= in_x && in_y && in_z;
      x1_ff      <= req_out_x;
      y1_ff      <= req_out_y;
      sx1_ff     <= src_x;
      sy1_ff     <= src_y;
      fill1_ff   <= fill_in;

      err2_ff    <= err1_ff;
      inside2_ff <= inside1_ff;
      x2_ff      <= x1_ff;
      sx2_ff     <= sx1_ff;
      fill2_ff   <= fill1_ff;

      err3_ff    <= err2_ff;
      inside3_ff <= inside2_ff;
      fill3_ff   <= fill2_ff;
   end

   // Drive the response beat, zero the index, fill and source fields of an erroneous one
   assign rsp_strobe       = valid3_ff;
   assign rsp_coord_error  = err3_ff;
   assign rsp_from_source  = inside3_ff && !err3_ff;
   assign rsp_source_index = (inside3_ff && !err3_ff) ? src3 : '0;
   assign rsp_dest_index   = err3_ff ? '0 : dst3;
   assign rsp_fill_value   = err3_ff ? '0 : FILL_W'(fill3_ff);

`ifndef NO_ASSERTIONS
   a_strobe_follows_start: assert property (@(posedge clock) disable iff (reset)
      start |-> ##3 rsp_strobe)
      else $error("response beat missing three cycles after start");

   a_strobe_has_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 3))
      else $error("response beat without a request");

   a_bad_channel_flags: assert property (@(posedge clock) disable iff (reset)
      (start && (req_channel >= CH_LIMIT)) |-> ##3 (rsp_coord_error && !rsp_from_source))
      else $error("bad channel not flagged");

   a_bad_x_flags: assert property (@(posedge clock) disable iff (reset)
      (start && (SIZE_W'(req_out_x) >= geom_x.out_size)) |-> ##3 rsp_coord_error)
      else $error("column past output width not flagged");
`endif

endmodule

`default_nettype wire

### dv/volume_center_crop_pad_address_test.sv
`timescale 1ns / 1ps

module volume_center_crop_pad_address_test;
   import vccpa_pkg::*;

   localparam int MAX_DIM     = 1024;
   localparam int CYCLE_LIMIT = 60000;
   localparam int PIPE_DEPTH  = 3;

   // One response beat of the address generator
   typedef struct {
      logic               from_source;
      logic [INDEX_W-1:0] source_index;
      logic [INDEX_W-1:0] dest_index;
      logic [FILL_W-1:0]  fill_value;
      logic               coord_error;
   } voxel_addr_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [COORD_W-1:0]    req_out_x;
   logic [COORD_W-1:0]    req_out_y;
   logic [COORD_W-1:0]    req_out_z;
   logic [CH_W-1:0]       req_channel;
   logic                  rsp_strobe;
   logic                  rsp_from_source;
   logic [INDEX_W-1:0]    rsp_source_index;
   logic [INDEX_W-1:0]    rsp_dest_index;
   logic [FILL_W-1:0]     rsp_fill_value;
   logic                  rsp_coord_error;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   // Shadow copy of the register file: six raw sizes, then the packed fills
   logic [SIZE_W-1:0]     size_reg [6];
   logic [CSR_DATA_W-1:0] fill_reg;

   voxel_addr_type pending_addr_q[$];
   voxel_addr_type rsp_want;
   int             mismatches;
   int             beats_sent;
   int             beats_checked;
   int             settings_count;
   int             idle_pct;
   int             cycle_count;

   volume_center_crop_pad_address dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_out_x        (req_out_x),
      .req_out_y        (req_out_y),
      .req_out_z        (req_out_z),
      .req_channel      (req_channel),
      .rsp_strobe       (rsp_strobe),
      .rsp_from_source  (rsp_from_source),
      .rsp_source_index (rsp_source_index),
      .rsp_dest_index   (rsp_dest_index),
      .rsp_fill_value   (rsp_fill_value),
      .rsp_coord_error  (rsp_coord_error),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // 100 MHz clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding",
                  cycle_count, pending_addr_q.size());
         $display("simulation failed");
         $finish;
      end
   end

   // Zero is taken as one, anything past MAX_DIM as MAX_DIM
   function automatic longint unsigned eff_size(input logic [SIZE_W-1:0] raw);
      if (raw == '0) return 1;
      if (raw > MAX_DIM) return MAX_DIM;
      return raw;
   endfunction

   // Map one output coordinate onto the source axis; returns 1 inside the source
   function automatic bit axis_to_source(input longint unsigned d,
                                         input longint unsigned in_sz,
                                         input longint unsigned out_sz,
                                         output longint unsigned src);
      longint unsigned pad;
      src = 0;
      if (out_sz >= in_sz) begin
         pad = (out_sz - in_sz + 1) >> 1;
         if (d < pad || d >= pad + in_sz) return 0;
         src = d - pad;
         return 1;
      end
      src = d + ((in_sz - out_sz - 1) >> 1);
      return 1;
   endfunction

   // Expected addresses of one output voxel under the current register shadow
   function automatic voxel_addr_type map_voxel(input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y,
                                                input logic [COORD_W-1:0] z,
                                                input logic [CH_W-1:0] c);
      voxel_addr_type  r;
      longint unsigned ix, iy, iz, ox, oy, oz;
      longint unsigned sx, sy, sz, lin;
      bit              hit_x, hit_y, hit_z;
      ix = eff_size(size_reg[REG_IN_SIZE_X]);
      iy = eff_size(size_reg[REG_IN_SIZE_Y]);
      iz = eff_size(size_reg[REG_IN_SIZE_Z]);
      ox = eff_size(size_reg[REG_OUT_SIZE_X]);
      oy = eff_size(size_reg[REG_OUT_SIZE_Y]);
      oz = eff_size(size_reg[REG_OUT_SIZE_Z]);
      r.from_source  = 1'b0;
      r.source_index = '0;
      r.dest_index   = '0;
      r.fill_value   = '0;
      r.coord_error  = 1'b0;
      // Out-of-range voxel or channel: error only, everything else zero
      if (x >= ox || y >= oy || z >= oz || c >= NUM_FILL) begin
         r.coord_error = 1'b1;
         return r;
      end
      lin = c * ox * oy * oz + z * ox * oy + y * ox + x;
      r.dest_index = lin[INDEX_W-1:0];
      r.fill_value = fill_reg[FILL_W*c +: FILL_W];
      hit_x = axis_to_source(x, ix, ox, sx);
      hit_y = axis_to_source(y, iy, oy, sy);
      hit_z = axis_to_source(z, iz, oz, sz);
      if (hit_x && hit_y && hit_z) begin
         lin = c * ix * iy * iz + sz * ix * iy + sy * ix + sx;
         r.from_source  = 1'b1;
         r.source_index = lin[INDEX_W-1:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // Compare each response beat with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_addr_q.size() == 0) begin
            report_mismatch($sformatf("unexpected beat, dest_index 0x%0h", rsp_dest_index));
         end else begin
            rsp_want = pending_addr_q.pop_front();
            beats_checked++;
            if (rsp_from_source !== rsp_want.from_source)
               report_mismatch($sformatf("beat %0d from_source %b, expected %b",
                  beats_checked, rsp_from_source, rsp_want.from_source));
            if (rsp_source_index !== rsp_want.source_index)
               report_mismatch($sformatf("beat %0d source_index 0x%0h, expected 0x%0h",
                  beats_checked, rsp_source_index, rsp_want.source_index));
            if (rsp_dest_index !== rsp_want.dest_index)
               report_mismatch($sformatf("beat %0d dest_index 0x%0h, expected 0x%0h",
                  beats_checked, rsp_dest_index, rsp_want.dest_index));
            if (rsp_fill_value !== rsp_want.fill_value)
               report_mismatch($sformatf("beat %0d fill_value 0x%0h, expected 0x%0h",
                  beats_checked, rsp_fill_value, rsp_want.fill_value));
            if (rsp_coord_error !== rsp_want.coord_error)
               report_mismatch($sformatf("beat %0d coord_error %b, expected %b",
                  beats_checked, rsp_coord_error, rsp_want.coord_error));
         end
      end
   end

   // Send one voxel; entered and left at a falling edge, start left high
   task automatic send_voxel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [COORD_W-1:0] z, input logic [CH_W-1:0] c);
      if ($urandom_range(0, 99) < idle_pct) begin
         start = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      start       = 1'b1;
      req_out_x   = x;
      req_out_y   = y;
      req_out_z   = z;
      req_channel = c;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_addr_q.push_back(map_voxel(x, y, z, c));
      beats_sent++;
      @(negedge clock);
   endtask

   // Hold off requests until every beat in flight has come back
   task automatic drain;
      start = 1'b0;
      while (pending_addr_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      if (idx == REG_FILL_VALUES) fill_reg = data;
      else size_reg[int'(idx)] = data[SIZE_W-1:0];
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Program a full register setting on an idle block
   task automatic program_volume(input logic [CSR_DATA_W-1:0] in_x,
                                 input logic [CSR_DATA_W-1:0] in_y,
                                 input logic [CSR_DATA_W-1:0] in_z,
                                 input logic [CSR_DATA_W-1:0] out_x,
                                 input logic [CSR_DATA_W-1:0] out_y,
                                 input logic [CSR_DATA_W-1:0] out_z,
                                 input logic [CSR_DATA_W-1:0] fills);
      drain();
      write_reg(REG_IN_SIZE_X, in_x);
      write_reg(REG_IN_SIZE_Y, in_y);
      write_reg(REG_IN_SIZE_Z, in_z);
      write_reg(REG_OUT_SIZE_X, out_x);
      write_reg(REG_OUT_SIZE_Y, out_y);
      write_reg(REG_OUT_SIZE_Z, out_z);
      write_reg(REG_FILL_VALUES, fills);
      settings_count++;
      // let the last write reach the address logic before the next beat
      repeat (PIPE_DEPTH) @(negedge clock);
   endtask

   // All sizes one and zero fills after reset
   task automatic test_reset_values;
      send_voxel(10'd0, 10'd0, 10'd0, 2'd0);
      send_voxel(10'd0, 10'd0, 10'd0, 2'd1);
      send_voxel(10'd0, 10'd0, 10'd0, 2'd2);
      send_voxel(10'd1, 10'd0, 10'd0, 2'd0);
      send_voxel(10'd0, 10'd0, 10'd0, 2'd3);
      send_voxel(10'd1023, 10'd1023, 10'd1023, 2'd0);
   endtask

   // Pad on x, crop on y, equal sizes on z; probe the overlap borders
   task automatic test_pad_crop_edges;
      program_volume(48'd4, 48'd7, 48'd5, 48'd8, 48'd2, 48'd5, 48'hA5A5_1234_FFFF);
      send_voxel(10'd1, 10'd0, 10'd0, 2'd0);
      send_voxel(10'd2, 10'd0, 10'd0, 2'd0);
      send_voxel(10'd5, 10'd1, 10'd4, 2'd1);
      send_voxel(10'd6, 10'd1, 10'd4, 2'd1);
      send_voxel(10'd7, 10'd1, 10'd4, 2'd2);
      send_voxel(10'd3, 10'd0, 10'd2, 2'd2);
      send_voxel(10'd8, 10'd0, 10'd0, 2'd0);
      send_voxel(10'd0, 10'd2, 10'd0, 2'd1);
      send_voxel(10'd0, 10'd0, 10'd5, 2'd2);
   endtask

   // Zero and oversize registers clamp; largest volume gives the largest indexes
   task automatic test_size_clamp;
      program_volume(48'd0, 48'd1024, {37'h1F_FFFF_FFFF, 11'd2047},
                     48'd2047, 48'd1024, 48'd1024, 48'hFFFF_FFFF_FFFF);
      send_voxel(10'd511, 10'd0, 10'd0, 2'd0);
      send_voxel(10'd512, 10'd0, 10'd0, 2'd1);
      send_voxel(10'd513, 10'd512, 10'd512, 2'd1);
      send_voxel(10'd1023, 10'd1023, 10'd1023, 2'd2);
      send_voxel(10'd512, 10'd1023, 10'd1023, 2'd2);
      send_voxel(10'd512, 10'd0, 10'd0, 2'd3);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_size;
      int sel;
      logic [CSR_DATA_W-1:0] v;
      sel = $urandom_range(0, 9);
      if (sel < 6) v = CSR_DATA_W'($urandom_range(1, 12));
      else if (sel < 8) v = CSR_DATA_W'($urandom_range(1, 1024));
      else if (sel == 8) v = CSR_DATA_W'($urandom_range(1025, 2047));
      else v = '0;
      // junk above the size field must be ignored
      if ($urandom_range(0, 3) == 0)
         v[CSR_DATA_W-1:SIZE_W] = (CSR_DATA_W-SIZE_W)'({$urandom, $urandom});
      return v;
   endfunction

   // Random settings; mostly voxels inside the output volume, some noise
   task automatic test_random_volumes(input int phases, input int beats_per_phase);
      logic [CSR_DATA_W-1:0] sz [6];
      longint unsigned       ox, oy, oz;
      for (int p = 0; p < phases; p++) begin
         for (int i = 0; i < 6; i++) sz[i] = pick_size();
         // sometimes make axes equal in and out
         if ($urandom_range(0, 3) == 0) begin
            sz[3] = sz[0];
            sz[4] = sz[1];
            sz[5] = sz[2];
         end
         program_volume(sz[0], sz[1], sz[2], sz[3], sz[4], sz[5],
                        ($urandom_range(0, 7) == 0) ? '0
                                                    : CSR_DATA_W'({$urandom, $urandom}));
         idle_pct = (p == 3) ? 0 : 25;
         ox = eff_size(size_reg[REG_OUT_SIZE_X]);
         oy = eff_size(size_reg[REG_OUT_SIZE_Y]);
         oz = eff_size(size_reg[REG_OUT_SIZE_Z]);
         for (int n = 0; n < beats_per_phase; n++) begin
            if ($urandom_range(0, 99) < 85)
               send_voxel(COORD_W'($urandom_range(0, int'(ox) - 1)),
                          COORD_W'($urandom_range(0, int'(oy) - 1)),
                          COORD_W'($urandom_range(0, int'(oz) - 1)),
                          CH_W'($urandom_range(0, 2)));
            else
               send_voxel(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                          CH_W'($urandom_range(0, 3)));
         end
      end
      idle_pct = 25;
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_out_x        = '0;
      req_out_y        = '0;
      req_out_z        = '0;
      req_channel      = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      for (int i = 0; i < 6; i++) size_reg[i] = 11'd1;
      fill_reg       = '0;
      mismatches     = 0;
      beats_sent     = 0;
      beats_checked  = 0;
      settings_count = 0;
      idle_pct       = 25;
      cycle_count    = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_pad_crop_edges();
      test_size_clamp();
      test_random_volumes(10, 50);

      // wait for the last beats, then let the bench idle before reporting
      drain();
      repeat (PIPE_DEPTH + 5) @(posedge clock);

      $display("%0d voxels sent, %0d beats checked over %0d register settings",
               beats_sent, beats_checked, settings_count);
      $display("covered pad, crop and equal axes, clamped sizes, bad voxels and channels");
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("simulation failed");
      end
      $finish;
   end

endmodule
